// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, ante, cons)
`define ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/rsw_pkg.sv
// ----------------------------------------------------------------------------
// rsw_pkg
// Shared constants and codes of the rate STDP weight update block.
// ----------------------------------------------------------------------------
package rsw_pkg;

    localparam int DEF_GROUPS = 4;
    localparam int DEF_WINDOW = 100;

    localparam int OP_W    = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int RATE_W  = 16;
    localparam int GROUP_W = 3;
    localparam int CSR_IDX_W  = 2;
    localparam int CSR_DATA_W = 24;

    localparam logic [OP_W-1:0] OP_KERNEL = 2'd0;
    localparam logic [OP_W-1:0] OP_WEIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_RATE   = 2'd2;
    // Reserved operation code; the block ignores it.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam logic [CSR_IDX_W-1:0] REG_TOTAL  = 2'd0;
    localparam logic [CSR_IDX_W-1:0] REG_PERIOD = 2'd1;
    localparam logic [CSR_IDX_W-1:0] REG_SHIFT  = 2'd2;

    localparam logic [23:0] RST_TOTAL  = 24'hFFFFFF;
    localparam logic [9:0]  RST_PERIOD = 10'd10;
    localparam logic [5:0]  RST_SHIFT  = 6'd24;

endpackage

// File: rtl/core/rsw_if.sv
// ----------------------------------------------------------------------------
// rsw channel interfaces
// Valid/ready channels for input items, weight results and register writes.
// ----------------------------------------------------------------------------
interface rsw_item_if;
    import rsw_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [OP_W-1:0]            operation;
    logic [INDEX_W-1:0]         table_index;
    logic signed [VALUE_W-1:0]  table_value;
    logic                       changeable;
    logic [RATE_W-1:0]          rate_value;
    modport source (output valid, operation, table_index, table_value, changeable,
                    rate_value, input ready);
    modport sink   (input valid, operation, table_index, table_value, changeable,
                    rate_value, output ready);
endinterface

interface rsw_result_if;
    import rsw_pkg::*;
    logic                       valid;
    logic                       ready;
    logic [GROUP_W-1:0]         source_group;
    logic [GROUP_W-1:0]         target_group;
    logic signed [VALUE_W-1:0]  weight;
    logic                       last;
    modport source (output valid, source_group, target_group, weight, last, input ready);
    modport sink   (input valid, source_group, target_group, weight, last, output ready);
endinterface

interface rsw_csr_if;
    import rsw_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CSR_IDX_W-1:0]   index;
    logic [CSR_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: rtl/core/rate_stdp_weight_update.sv
// ----------------------------------------------------------------------------
// rate_stdp_weight_update
// Rate-based STDP: keeps a rate history per group and, on eligible update
// times, moves every changeable pair weight by kernel-weighted correlations.
// ----------------------------------------------------------------------------
//  channel  | dir | contents
//  ---------+-----+-------------------------------------------------------
//  item     | in  | kernel load, pair weight load or one rate sample
//  result   | out | one pair weight per transfer, last on the final pair
//  csr      | in  | register index and write data, always ready
//
// Loads and non-final rate samples are written while idle. The sample that closes a
// time step then runs a serial remainder of time by update_period. An update
// sends each changeable pair through the shared multiply-accumulate pipeline
// while fixed pairs skip it, and the result channel can stall each pair. After
// reset a clearing pass zeroes the rate history before items are taken.
`include "assert_macros.svh"

module rate_stdp_weight_update #(
    parameter int GROUPS = rsw_pkg::DEF_GROUPS,
    parameter int WINDOW = rsw_pkg::DEF_WINDOW
) (
    input  logic          clk,
    input  logic          rst_n,
    rsw_item_if.sink      item,
    rsw_result_if.source  result,
    rsw_csr_if.sink       csr
);
    import rsw_pkg::*;

    localparam int TAPS  = 2 * WINDOW + 1;
    localparam int DEPTH = WINDOW + 1;
    localparam int PAIRS = GROUPS * GROUPS;
    localparam int RENT  = DEPTH * GROUPS;
    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int PAW   = (PAIRS > 1) ? $clog2(PAIRS) : 1;
    localparam int KAW   = $clog2(TAPS);
    localparam int SW    = $clog2(DEPTH);
    localparam int RAW   = $clog2(RENT);
    localparam int CW    = $clog2(2 * WINDOW + 2);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_MAC   = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;
    localparam logic [2:0] ST_FIN   = 3'd6;

    // Memories
    logic signed [31:0] kernel_mem [TAPS];
    logic signed [31:0] weight_mem [PAIRS];
    logic [15:0]        rate_mem   [RENT];
    logic [15:0]        cur_rate_reg [GROUPS];

    // Control
    logic [2:0]       state_reg, state_next;
    logic [RAW-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [GW-1:0]    gpos_reg, gpos_next;
    logic [23:0]      time_reg, time_next;
    logic [SW-1:0]    head_reg, head_next;
    logic [SW-1:0]    upd_head_reg, upd_head_next;
    logic             elig_reg, elig_next;
    logic [23:0]      div_reg, div_next;
    logic [9:0]       rem_reg, rem_next;
    logic [4:0]       mod_cnt_reg, mod_cnt_next;
    logic [PAW-1:0]   pair_reg, pair_next;
    logic [GW-1:0]    src_reg, src_next;
    logic [GW-1:0]    tgt_reg, tgt_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [KAW-1:0]   kaddr_reg, kaddr_next;
    logic [SW-1:0]    slot_reg, slot_next;
    logic [PAIRS-1:0] chg_reg, chg_next;
    logic [23:0]      total_reg;
    logic [9:0]       period_reg;
    logic [5:0]       pshift_reg;

    // MAC pipeline
    logic               v1_reg, v2_reg, v3_reg, v4_reg, v1_next;
    logic signed [31:0] kq_reg, k2_reg;
    logic [15:0]        rq_reg, f1_reg;
    logic [31:0]        prod_reg;
    logic signed [63:0] p3_reg, sh_reg;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [31:0] wq_reg;

    // Output register
    logic               out_valid_reg, out_valid_next;
    logic [GW-1:0]      out_src_reg, out_tgt_reg;
    logic signed [31:0] out_w_reg;
    logic               out_last_reg;
    logic               out_load;

    // Datapath helpers
    logic               in_fire, half;
    logic [RAW-1:0]     raddr;
    logic [GW-1:0]      fsel;
    logic [10:0]        trial;
    logic               rate_we;
    logic [RAW-1:0]     rate_waddr;
    logic [15:0]        rate_wdata;
    logic               w_we;
    logic [PAW-1:0]     w_waddr;
    logic signed [31:0] w_wdata;
    logic signed [64:0] wide_sum;
    logic signed [31:0] new_weight;
    logic signed [63:0] acc_sum;

    assign item.ready = (state_reg == ST_IDLE);
    assign in_fire    = item.valid && item.ready;
    assign csr.ready  = 1'b1;

    assign half  = (cnt_reg > CW'(WINDOW));
    assign raddr = RAW'(32'(slot_reg) * GROUPS + 32'(half ? src_reg : tgt_reg));
    assign fsel  = half ? tgt_reg : src_reg;
    assign trial = {rem_reg, div_reg[23]};

    assign wide_sum = 65'(wq_reg) + 65'(acc_reg);
    always_comb
    begin
        if (!chg_reg[pair_reg])
            new_weight = wq_reg;
        else if (wide_sum[64:31] == {34{wide_sum[64]}})
            new_weight = wide_sum[31:0];
        else if (wide_sum[64])
            new_weight = 32'sh8000_0000;
        else
            new_weight = 32'sh7FFF_FFFF;
    end

    assign out_load = (state_reg == ST_FIN) && (!out_valid_reg || result.ready);

    // Saturating accumulate of the shifted product, cleared when a pair is read.
    assign acc_sum = acc_reg + sh_reg;
    always_comb
    begin
        acc_next = acc_reg;
        if (state_reg == ST_RD)
            acc_next = '0;
        else if (v4_reg)
        begin
            if ((acc_reg[63] == sh_reg[63]) && (acc_sum[63] != acc_reg[63]))
                acc_next = acc_reg[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            else
                acc_next = acc_sum;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        gpos_next     = gpos_reg;
        time_next     = time_reg;
        head_next     = head_reg;
        upd_head_next = upd_head_reg;
        elig_next     = elig_reg;
        div_next      = div_reg;
        rem_next      = rem_reg;
        mod_cnt_next  = mod_cnt_reg;
        pair_next     = pair_reg;
        src_next      = src_reg;
        tgt_next      = tgt_reg;
        cnt_next      = cnt_reg;
        kaddr_next    = kaddr_reg;
        slot_next     = slot_reg;
        chg_next      = chg_reg;
        v1_next       = 1'b0;
        rate_we       = 1'b0;
        rate_waddr    = RAW'(32'(head_reg) * GROUPS + 32'(gpos_reg));
        rate_wdata    = item.rate_value;
        w_we          = 1'b0;
        w_waddr       = item.table_index[PAW-1:0];
        w_wdata       = item.table_value;
        out_valid_next = out_valid_reg && !result.ready;

        case (state_reg)
            ST_CLEAR:
            begin
                rate_we    = 1'b1;
                rate_waddr = clr_cnt_reg;
                rate_wdata = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == RAW'(RENT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (item.operation == OP_WEIGHT &&
                        {1'b0, item.table_index} < 11'(PAIRS))
                    begin
                        w_we = 1'b1;
                        chg_next[item.table_index[PAW-1:0]] = item.changeable;
                    end
                    else if (item.operation == OP_RATE)
                    begin
                        rate_we = 1'b1;
                        if (gpos_reg == GW'(GROUPS - 1))
                        begin
                            gpos_next     = '0;
                            upd_head_next = head_reg;
                            elig_next     = (time_reg >= 24'(WINDOW)) &&
                                            (({1'b0, time_reg} + 25'(WINDOW)) <
                                             {1'b0, total_reg});
                            div_next      = time_reg;
                            rem_next      = '0;
                            mod_cnt_next  = '0;
                            time_next     = time_reg + 24'd1;
                            head_next     = (head_reg == SW'(DEPTH - 1)) ? '0
                                                                         : head_reg + 1'b1;
                            state_next    = ST_MOD;
                        end
                        else
                            gpos_next = gpos_reg + 1'b1;
                    end
                end
            end
            ST_MOD:
            begin
                // One restoring remainder step per cycle, dividend MSB first.
                if (trial >= {1'b0, period_reg})
                    rem_next = 10'(trial - {1'b0, period_reg});
                else
                    rem_next = trial[9:0];
                div_next     = {div_reg[22:0], 1'b0};
                mod_cnt_next = mod_cnt_reg + 5'd1;
                if (mod_cnt_reg == 5'd23)
                begin
                    if (elig_reg && period_reg != 10'd0 && rem_next == 10'd0)
                    begin
                        pair_next  = '0;
                        src_next   = '0;
                        tgt_next   = '0;
                        state_next = ST_RD;
                    end
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_RD:
            begin
                cnt_next   = '0;
                kaddr_next = '0;
                slot_next  = (upd_head_reg == SW'(DEPTH - 1)) ? '0 : upd_head_reg + 1'b1;
                state_next = chg_reg[pair_reg] ? ST_MAC : ST_FIN;
            end
            ST_MAC:
            begin
                v1_next  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                // Both halves meet at the current slot and the middle tap.
                if (cnt_reg != CW'(WINDOW))
                begin
                    kaddr_next = kaddr_reg + 1'b1;
                    if (!half)
                        slot_next = (slot_reg == SW'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                    else
                        slot_next = (slot_reg == '0) ? SW'(DEPTH - 1) : slot_reg - 1'b1;
                end
                if (cnt_reg == CW'(2 * WINDOW + 1))
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (!v1_reg && !v2_reg && !v3_reg && !v4_reg)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    w_we    = 1'b1;
                    w_waddr = pair_reg;
                    w_wdata = new_weight;
                    if (pair_reg == PAW'(PAIRS - 1))
                        state_next = ST_IDLE;
                    else
                    begin
                        pair_next = pair_reg + 1'b1;
                        if (tgt_reg == GW'(GROUPS - 1))
                        begin
                            tgt_next = '0;
                            src_next = src_reg + 1'b1;
                        end
                        else
                            tgt_next = tgt_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            gpos_reg      <= '0;
            time_reg      <= '0;
            head_reg      <= '0;
            upd_head_reg  <= '0;
            elig_reg      <= 1'b0;
            mod_cnt_reg   <= '0;
            pair_reg      <= '0;
            src_reg       <= '0;
            tgt_reg       <= '0;
            cnt_reg       <= '0;
            kaddr_reg     <= '0;
            slot_reg      <= '0;
            chg_reg       <= '0;
            total_reg     <= RST_TOTAL;
            period_reg    <= RST_PERIOD;
            pshift_reg    <= RST_SHIFT;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            gpos_reg      <= gpos_next;
            time_reg      <= time_next;
            head_reg      <= head_next;
            upd_head_reg  <= upd_head_next;
            elig_reg      <= elig_next;
            mod_cnt_reg   <= mod_cnt_next;
            pair_reg      <= pair_next;
            src_reg       <= src_next;
            tgt_reg       <= tgt_next;
            cnt_reg       <= cnt_next;
            kaddr_reg     <= kaddr_next;
            slot_reg      <= slot_next;
            chg_reg       <= chg_next;
            v1_reg        <= v1_next;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= out_valid_next;
            if (csr.valid)
            begin
                case (csr.index)
                    REG_TOTAL:  total_reg  <= csr.data;
                    REG_PERIOD: period_reg <= csr.data[9:0];
                    REG_SHIFT:  pshift_reg <= csr.data[5:0];
                    default:    ;
                endcase
            end
        end
    end

    // Payload registers without reset.
    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        rem_reg  <= rem_next;
        acc_reg  <= acc_next;
        prod_reg <= f1_reg * rq_reg;
        k2_reg   <= kq_reg;
        p3_reg   <= k2_reg * $signed({1'b0, prod_reg});
        sh_reg   <= p3_reg >>> pshift_reg;
        f1_reg   <= cur_rate_reg[fsel];
        if (out_load)
        begin
            out_src_reg  <= src_reg;
            out_tgt_reg  <= tgt_reg;
            out_w_reg    <= new_weight;
            out_last_reg <= (pair_reg == PAW'(PAIRS - 1));
        end
        if (in_fire && item.operation == OP_RATE)
            cur_rate_reg[gpos_reg] <= item.rate_value;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && item.operation == OP_KERNEL && {1'b0, item.table_index} < 11'(TAPS))
            kernel_mem[item.table_index[KAW-1:0]] <= item.table_value;
        kq_reg <= kernel_mem[kaddr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (w_we)
            weight_mem[w_waddr] <= w_wdata;
        wq_reg <= weight_mem[pair_reg];
    end

    always_ff @(posedge clk)
    begin
        if (rate_we)
            rate_mem[rate_waddr] <= rate_wdata;
        rq_reg <= rate_mem[raddr];
    end

    assign result.valid        = out_valid_reg;
    assign result.source_group = GROUP_W'(out_src_reg);
    assign result.target_group = GROUP_W'(out_tgt_reg);
    assign result.weight       = out_w_reg;
    assign result.last         = out_last_reg;

    `ASSERT_IMPLIES(a_mac_in_update, v4_reg, (state_reg == ST_MAC || state_reg == ST_DRAIN))
    `ASSERT_IMPLIES(a_fin_drained, state_reg == ST_FIN, !(v1_reg || v2_reg || v3_reg || v4_reg))
    `ASSERT_IMPLIES(a_clear_quiet, state_reg == ST_CLEAR, !out_valid_reg && !item.ready)

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// STDP weight update regression
// Loads kernel taps and pair weights, streams rate samples through several
// register settings and checks every emitted pair weight against a
// cycle-free predictor of the learning rule, with random stalls both sides.
// ----------------------------------------------------------------------------
module tb;
    import rsw_pkg::*;

    localparam int GROUPS = DEF_GROUPS;
    localparam int WINDOW = DEF_WINDOW;
    localparam int TAPS   = 2 * WINDOW + 1;
    localparam int DEPTH  = WINDOW + 1;
    localparam int PAIRS  = GROUPS * GROUPS;
    localparam int IDLE_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 64;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = -64'sh7FFF_FFFF_FFFF_FFFF - 1;

    typedef struct {
        logic [GROUP_W-1:0] src;
        logic [GROUP_W-1:0] tgt;
        int                 weight;
        logic               last;
    } pair_weight_t;

    typedef struct {
        logic [OP_W-1:0]    op;
        logic [INDEX_W-1:0] idx;
        int                 value;
        logic               chg;
        logic [RATE_W-1:0]  rate;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rsw_item_if   item_ch ();
    rsw_result_if res_ch ();
    rsw_csr_if    csr_ch ();

    rate_stdp_weight_update u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .csr    (csr_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state.
    logic [23:0]       run_length;
    logic [9:0]        period;
    logic [5:0]        shift;
    int                kernel [TAPS];
    int                weights [PAIRS];
    logic              movable [PAIRS];
    logic [RATE_W-1:0] history [DEPTH][GROUPS];
    logic [23:0]       step_time;
    int                group_pos;
    int                head;

    pair_weight_t weights_due [$];
    int  failures = 0;
    bit  calm = 0;
    int  idle_cycles = 0;

    function automatic longint sat_add(longint a, longint b);
        longint s;
        s = a + b;
        if (a >= 0 && b >= 0 && s < 0)
            return S64_MAX;
        if (a < 0 && b < 0 && s >= 0)
            return S64_MIN;
        return s;
    endfunction

    function automatic longint scaled_term(int k, logic [RATE_W-1:0] ra,
                                           logic [RATE_W-1:0] rb);
        longint p;
        p = longint'(k) * (longint'(ra) * longint'(rb));
        return p >>> shift;
    endfunction

    function automatic logic [RATE_W-1:0] rate_ago(int d, int g);
        return history[(head + DEPTH - d) % DEPTH][g];
    endfunction

    function automatic int moved_weight(int a, int b, int w);
        longint acc;
        longint nw;
        acc = 0;
        for (int tau = 0; tau <= WINDOW; tau++)
            acc = sat_add(acc, scaled_term(kernel[tau], rate_ago(0, a),
                                           rate_ago(WINDOW - tau, b)));
        for (int tau = 0; tau <= WINDOW; tau++)
            acc = sat_add(acc, scaled_term(kernel[tau + WINDOW], rate_ago(0, b),
                                           rate_ago(tau, a)));
        nw = sat_add(longint'(w), acc);
        if (nw > 64'sd2147483647)
            nw = 64'sd2147483647;
        if (nw < -64'sd2147483648)
            nw = -64'sd2147483648;
        return int'(nw);
    endfunction

    task automatic stdp_predict(stim_row_t s);
        pair_weight_t pw;
        bit fire;
        if (s.op == OP_KERNEL)
        begin
            if (s.idx < TAPS)
                kernel[s.idx] = s.value;
        end
        else if (s.op == OP_WEIGHT)
        begin
            if (s.idx < PAIRS)
            begin
                weights[s.idx] = s.value;
                movable[s.idx] = s.chg;
            end
        end
        else if (s.op == OP_RATE)
        begin
            history[head][group_pos] = s.rate;
            if (group_pos + 1 < GROUPS)
                group_pos++;
            else
            begin
                fire = period != 0 && (step_time % period) == 0 && step_time > 0 &&
                       step_time >= WINDOW &&
                       (longint'(step_time) + WINDOW < longint'(run_length));
                if (fire)
                    for (int p = 0; p < PAIRS; p++)
                    begin
                        if (movable[p])
                            weights[p] = moved_weight(p / GROUPS, p % GROUPS, weights[p]);
                        pw.src = GROUP_W'(p / GROUPS);
                        pw.tgt = GROUP_W'(p % GROUPS);
                        pw.weight = weights[p];
                        pw.last = (p == PAIRS - 1);
                        weights_due.push_back(pw);
                    end
                group_pos = 0;
                step_time = step_time + 24'd1;
                head = (head + 1) % DEPTH;
            end
        end
    endtask

    function automatic int gap_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(stim_row_t s);
        int gap;
        gap = gap_len();
        @(negedge clk);
        if (gap > 0)
        begin
            item_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_ch.operation   = s.op;
        item_ch.table_index = s.idx;
        item_ch.table_value = s.value;
        item_ch.changeable  = s.chg;
        item_ch.rate_value  = s.rate;
        item_ch.valid       = 1'b1;
        forever
        begin
            @(posedge clk);
            if (item_ch.ready)
                break;
        end
        stdp_predict(s);
    endtask

    task automatic write_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
        // Drop the last item first so it is not taken again while waiting.
        @(negedge clk);
        item_ch.valid = 1'b0;
        // Let any sample still in flight finish before touching a register.
        wait (weights_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        csr_ch.index = index;
        csr_ch.data  = data;
        csr_ch.valid = 1'b1;
        forever
        begin
            @(posedge clk);
            if (csr_ch.ready)
                break;
        end
        @(negedge clk);
        csr_ch.valid = 1'b0;
        case (index)
            REG_TOTAL:  run_length = data;
            REG_PERIOD: period = data[9:0];
            REG_SHIFT:  shift = data[5:0];
            default: ;
        endcase
    endtask

    function automatic int pick_word();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 32'h7FFF_FFFF;
        if (r == 1)
            return 32'h8000_0000;
        if (r < 5)
            return int'($urandom);
        return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sh100000;
    endfunction

    function automatic logic [RATE_W-1:0] pick_rate();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return RATE_W'($urandom);
    endfunction

    task automatic load_tables();
        stim_row_t s;
        for (int i = 0; i < TAPS; i++)
        begin
            s = '{OP_KERNEL, INDEX_W'(i), pick_word(), 1'($urandom), RATE_W'($urandom)};
            send_item(s);
        end
        for (int i = 0; i < PAIRS; i++)
        begin
            s = '{OP_WEIGHT, INDEX_W'(i), pick_word(), $urandom_range(0, 3) != 0,
                  RATE_W'($urandom)};
            send_item(s);
        end
    endtask

    task automatic send_noise();
        stim_row_t s;
        s = '{OP_RATE, '0, int'($urandom), 1'($urandom), RATE_W'($urandom)};
        case ($urandom_range(0, 4))
            0: s.op = OP_UNUSED;
            1: begin s.op = OP_KERNEL; s.idx = INDEX_W'($urandom_range(TAPS, 1023)); end
            2: begin s.op = OP_WEIGHT; s.idx = INDEX_W'($urandom_range(PAIRS, 1023)); end
            3: begin s.op = OP_WEIGHT; s.idx = INDEX_W'($urandom_range(0, PAIRS - 1)); end
            default: begin s.op = OP_KERNEL; s.idx = INDEX_W'($urandom_range(0, TAPS - 1)); end
        endcase
        s.value = pick_word();
        send_item(s);
    endtask

    task automatic run_steps(int steps);
        stim_row_t s;
        for (int t = 0; t < steps; t++)
            for (int g = 0; g < GROUPS; g++)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_noise();
                s = '{OP_RATE, INDEX_W'($urandom), int'($urandom), 1'($urandom),
                      pick_rate()};
                send_item(s);
            end
    endtask

    // Directed rows: field extremes, every operation and the ignored cases.
    stim_row_t directed [] = '{
        '{OP_KERNEL, 10'd0,    32'h7FFF_FFFF, 1'b0, 16'h0000},
        '{OP_KERNEL, 10'd200,  32'h8000_0000, 1'b1, 16'hFFFF},
        '{OP_KERNEL, 10'd201,  32'h1234_5678, 1'b0, 16'h0000},
        '{OP_KERNEL, 10'd1023, 32'hFFFF_FFFF, 1'b1, 16'hFFFF},
        '{OP_WEIGHT, 10'd0,    32'h7FFF_FFFF, 1'b1, 16'h0000},
        '{OP_WEIGHT, 10'd15,   32'h8000_0000, 1'b1, 16'hFFFF},
        '{OP_WEIGHT, 10'd5,    32'h0000_0000, 1'b0, 16'h5555},
        '{OP_WEIGHT, 10'd16,   32'h0000_0001, 1'b1, 16'hAAAA},
        '{OP_WEIGHT, 10'd1023, 32'hAAAA_5555, 1'b0, 16'h0000},
        '{OP_UNUSED, 10'd1023, 32'hFFFF_FFFF, 1'b1, 16'hFFFF},
        '{OP_UNUSED, 10'd0,    32'h0000_0000, 1'b0, 16'h0000},
        '{OP_RATE,   10'd0,    32'h0000_0000, 1'b0, 16'h0000},
        '{OP_RATE,   10'd1023, 32'hFFFF_FFFF, 1'b1, 16'hFFFF},
        '{OP_RATE,   10'h155,  32'h5555_5555, 1'b0, 16'h8000},
        '{OP_RATE,   10'h2AA,  32'hAAAA_AAAA, 1'b1, 16'h0001},
        '{OP_RATE,   10'd0,    32'h0000_0000, 1'b0, 16'hFFFF},
        '{OP_RATE,   10'd0,    32'h0000_0000, 1'b0, 16'h00FF},
        '{OP_RATE,   10'd0,    32'h0000_0000, 1'b0, 16'hFF00},
        '{OP_RATE,   10'd0,    32'h0000_0000, 1'b0, 16'h0000}
    };

    // Result side: random stalls, checked against the oldest expectation.
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            res_ch.ready = 1'b0;
            stall_left--;
        end
        else
        begin
            res_ch.ready = 1'b1;
            if (!calm)
                stall_left = gap_len();
        end
    end

    always @(posedge clk)
    begin
        pair_weight_t e;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (weights_due.size() == 0)
            begin
                $error("unexpected weight transfer: src %0d tgt %0d weight %0d",
                       res_ch.source_group, res_ch.target_group, res_ch.weight);
                failures++;
            end
            else
            begin
                e = weights_due.pop_front();
                if (res_ch.source_group !== e.src)
                begin
                    $error("source_group: expected %0d, got %0d", e.src,
                           res_ch.source_group);
                    failures++;
                end
                if (res_ch.target_group !== e.tgt)
                begin
                    $error("target_group: expected %0d, got %0d", e.tgt,
                           res_ch.target_group);
                    failures++;
                end
                if (res_ch.weight !== e.weight)
                begin
                    $error("weight: expected %0d, got %0d", e.weight, res_ch.weight);
                    failures++;
                end
                if (res_ch.last !== e.last)
                begin
                    $error("last: expected %0d, got %0d", e.last, res_ch.last);
                    failures++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (csr_ch.valid && csr_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        item_ch.valid = 1'b0;
        item_ch.operation = '0;
        item_ch.table_index = '0;
        item_ch.table_value = '0;
        item_ch.changeable = 1'b0;
        item_ch.rate_value = '0;
        res_ch.ready = 1'b0;
        csr_ch.valid = 1'b0;
        csr_ch.index = '0;
        csr_ch.data = '0;
        run_length = RST_TOTAL;
        period = RST_PERIOD;
        shift = RST_SHIFT;
        foreach (kernel[i])
            kernel[i] = 0;
        foreach (weights[i])
        begin
            weights[i] = 0;
            movable[i] = 1'b0;
        end
        foreach (history[i, g])
            history[i][g] = '0;
        step_time = '0;
        group_pos = 0;
        head = 0;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed[i])
            send_item(directed[i]);

        // Update on every step, coarsest shift.
        write_reg(REG_TOTAL, 24'hFFFFFF);
        write_reg(REG_PERIOD, 24'd1);
        write_reg(REG_SHIFT, 24'd63);
        load_tables();
        run_steps(WINDOW + 4 - int'(step_time));

        // No shift, and an end bound that stops updates after a few steps.
        write_reg(REG_SHIFT, 24'd0);
        write_reg(REG_PERIOD, 24'd3);
        write_reg(REG_TOTAL, 24'(int'(step_time) + WINDOW + 7));
        run_steps(12);

        // Zero period, then the widest period with the shortest run.
        write_reg(REG_PERIOD, 24'd0);
        run_steps(4);
        write_reg(REG_PERIOD, 24'd1023);
        write_reg(REG_TOTAL, 24'd1);
        run_steps(4);

        // Mid shift, first with no idling on either side, then with random stalls.
        write_reg(REG_TOTAL, 24'hFFFFFF);
        write_reg(REG_PERIOD, 24'd2);
        write_reg(REG_SHIFT, 24'd20);
        calm = 1;
        run_steps(8);
        calm = 0;
        run_steps(6);

        @(negedge clk);
        item_ch.valid = 1'b0;
        wait (weights_due.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
